[hw/rtl/stsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_pkg
// shared types and constants for the sorted key table search/insert block
// ----------------------------------------------------------------------------
package stsi_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int KEY_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int POS_W       = 6;
   localparam int USED_W      = 7;

   localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(TABLE_DEPTH);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [USED_W-1:0]   entries_used;
   } result_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [KEY_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

endpackage

[hw/rtl/sorted_table_search_swap_insert_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_search_swap_insert_top
// sorted key table with binary search, swap on hit and ordered insert on miss
// ----------------------------------------------------------------------------
// Usage:
//   One req transaction carries a signed 32-bit key. It is looked up by binary
//   search over the valid entries. A hit swaps the entry with the next one
//   (unless it is the last); a miss inserts the key in order, moving larger
//   entries up; a miss on a full table drops the key. Each key gives exactly
//   one rsp transaction with status, position and the entry count after it.
// Timing:
//   req_tready is high only while the sequencer is idle. A key goes through
//   up to 7 binary search probes, then a swap (none on the last entry), a
//   drop on a full table, or a shift of the larger entries and an insert,
//   then the result hand-off, with req_tready back in the cycle after it.
//   The single table ram port pair (one read, one write per cycle) sets the
//   shift cost.
// Reset:
//   The table reads as empty after reset; no clearing pass is needed.
// Stall:
//   The result sits in an output register; the next key is accepted and
//   worked on while it waits, and only its own hand-off waits for rsp_tready.
// ----------------------------------------------------------------------------
module sorted_table_search_swap_insert_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [7:2] position, [14:8] entries_used
);

   import stsi_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        out_free;
   logic        res_valid;
   result_type  res;
   ram_req_type ram_req;
   logic [KEY_W-1:0] ram_rd_data;

   assign out_free = !rsp_valid_ff || rsp_tready;

   stsi_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_key     (req_tdata),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   stsi_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (KEY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.entries_used, rsp_ff.position, rsp_ff.status};

endmodule

[hw/rtl/stsi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_ram
// simple dual-port ram: one write port, one registered read port
// ----------------------------------------------------------------------------
module stsi_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/stsi_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_engine
// sequencer: binary search, swap on hit, shift-and-insert on miss
// ----------------------------------------------------------------------------
module stsi_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [stsi_pkg::KEY_W-1:0] req_key,
   input  logic                      out_free,
   output logic                      res_valid,
   output stsi_pkg::result_type      res,
   output stsi_pkg::ram_req_type     ram_req,
   input  logic [stsi_pkg::KEY_W-1:0] ram_rd_data
);

   import stsi_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PROBE    = 4'd1;
   localparam logic [3:0] S_COMPARE  = 4'd2;
   localparam logic [3:0] S_SWAP_RD  = 4'd3;
   localparam logic [3:0] S_SWAP_WR1 = 4'd4;
   localparam logic [3:0] S_SWAP_WR2 = 4'd5;
   localparam logic [3:0] S_SHIFT    = 4'd6;
   localparam logic [3:0] S_INSERT   = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [KEY_W-1:0]  tmp_ff, tmp_in;
   logic [IDX_W-1:0]  src_ff, src_in;
   logic [IDX_W-1:0]  wsrc_ff, wsrc_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              pend_ff, pend_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [CNT_W:0]    sum;
   logic [IDX_W-1:0]  mid;
   logic [CNT_W-1:0]  pos_next;

   assign sum      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = sum[IDX_W:1];
   assign pos_next = CNT_W'(pos_ff) + CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      pos_in    = pos_ff;
      tmp_in    = tmp_ff;
      src_in    = src_ff;
      wsrc_in   = wsrc_ff;
      left_in   = left_ff;
      pend_in   = pend_ff;
      status_in = status_ff;
      ram_req   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in   = req_key;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = mid;
               pos_in          = mid;
               state_in        = S_COMPARE;
            end else if (count_ff == COUNT_FULL) begin
               status_in = STATUS_FULL;
               pos_in    = '0;
               state_in  = S_DONE;
            end else begin
               // shift entries lo..count-1 up by one, highest first
               src_in    = IDX_W'(count_ff - CNT_W'(1));
               left_in   = count_ff - lo_ff;
               pend_in   = 1'b0;
               state_in  = S_SHIFT;
            end
         end
         S_COMPARE: begin
            if (ram_rd_data == key_ff) begin
               tmp_in    = ram_rd_data;
               status_in = STATUS_FOUND;
               state_in  = (pos_next < count_ff) ? S_SWAP_RD : S_DONE;
            end else if ($signed(ram_rd_data) < $signed(key_ff)) begin
               lo_in    = CNT_W'(pos_ff) + CNT_W'(1);
               state_in = S_PROBE;
            end else begin
               hi_in    = CNT_W'(pos_ff);
               state_in = S_PROBE;
            end
         end
         S_SWAP_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = IDX_W'(pos_next);
            state_in        = S_SWAP_WR1;
         end
         S_SWAP_WR1: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff;
            ram_req.wr_data = ram_rd_data;
            state_in        = S_SWAP_WR2;
         end
         S_SWAP_WR2: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = IDX_W'(pos_next);
            ram_req.wr_data = tmp_ff;
            state_in        = S_DONE;
         end
         S_SHIFT: begin
            // read of src overlaps the write of the entry read on the previous pass through this state
            if (pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = wsrc_ff + IDX_W'(1);
               ram_req.wr_data = ram_rd_data;
            end
            if (left_ff != '0) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = src_ff;
               wsrc_in         = src_ff;
               src_in          = src_ff - IDX_W'(1);
               left_in         = left_ff - CNT_W'(1);
               pend_in         = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = IDX_W'(lo_ff);
            ram_req.wr_data = key_ff;
            count_in        = count_ff + CNT_W'(1);
            pos_in          = IDX_W'(lo_ff);
            status_in       = STATUS_INSERTED;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      pos_ff    <= pos_in;
      tmp_ff    <= tmp_in;
      src_ff    <= src_in;
      wsrc_ff   <= wsrc_in;
      left_ff   <= left_in;
      status_ff <= status_in;
   end

   assign req_tready       = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_DONE) && out_free;
   assign res.status       = status_ff;
   assign res.position     = POS_W'(pos_ff);
   assign res.entries_used = USED_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("entry count above table depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INSERT |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not bump the count");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == STATUS_FULL |-> count_ff == COUNT_FULL && pos_ff == '0)
      else $error("full status without a full table");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> state_ff == S_SHIFT || state_ff == S_INSERT
                        || state_ff == S_SWAP_WR1 || state_ff == S_SWAP_WR2)
      else $error("table write outside a write state");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_INSERT |=> $stable(count_ff))
      else $error("count changed outside insert");

endmodule

[tb/key_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_table_checker
// watches both streams of the sorted key table, predicts each lookup and
// compares every rsp transaction against the oldest prediction in line
// ----------------------------------------------------------------------------
module key_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [1:0] status, [7:2] position, [14:8] entries_used
   output int          mismatch_count,
   output int          pending,
   output int          found_count,
   output int          inserted_count,
   output int          dropped_count
);

   import stsi_pkg::*;

   // shadow copy of the table
   logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
   int               entry_count;

   result_type       awaited_lookups [$];
   int               errors;
   int               lookups_seen;
   int               results_seen;

   assign mismatch_count = errors;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
      errors++;
   endtask

   function automatic result_type search_swap_insert(input logic [KEY_W-1:0] key);
      int               lo;
      int               hi;
      int               mid;
      int               pos;
      bit               hit;
      logic [KEY_W-1:0] held;
      result_type       res;
      lo  = 0;
      hi  = entry_count;
      pos = 0;
      hit = 1'b0;
      // plain binary search, even when earlier swaps broke the order
      while (lo < hi && !hit) begin
         mid = (lo + hi) / 2;
         if ($signed(table_keys[mid]) == $signed(key)) begin
            hit = 1'b1;
            pos = mid;
         end else if ($signed(table_keys[mid]) < $signed(key)) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      if (hit) begin
         res.status = STATUS_FOUND;
         if (pos + 1 < entry_count) begin
            held                = table_keys[pos];
            table_keys[pos]     = table_keys[pos + 1];
            table_keys[pos + 1] = held;
         end
      end else if (entry_count >= TABLE_DEPTH) begin
         res.status = STATUS_FULL;
         pos        = 0;
      end else begin
         for (int i = entry_count; i > lo; i--) table_keys[i] = table_keys[i - 1];
         table_keys[lo] = key;
         entry_count++;
         res.status = STATUS_INSERTED;
         pos        = lo;
      end
      res.position     = POS_W'(pos);
      res.entries_used = USED_W'(entry_count);
      return res;
   endfunction

   always @(posedge clock) begin
      result_type exp;
      result_type got;
      if (reset) begin
         entry_count    = 0;
         pending        = 0;
         errors         = 0;
         lookups_seen   = 0;
         results_seen   = 0;
         found_count    = 0;
         inserted_count = 0;
         dropped_count  = 0;
         awaited_lookups.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tdata[1:0];
            got.position     = rsp_tdata[7:2];
            got.entries_used = rsp_tdata[14:8];
            if (awaited_lookups.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, data %h", rsp_tdata));
            end else begin
               exp = awaited_lookups.pop_front();
               if (got.status !== exp.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, exp.status));
               if (got.position !== exp.position)
                  report_mismatch($sformatf("position %0d, expected %0d",
                                            got.position, exp.position));
               if (got.entries_used !== exp.entries_used)
                  report_mismatch($sformatf("entries_used %0d, expected %0d",
                                            got.entries_used, exp.entries_used));
               if (rsp_tdata[15] !== 1'b0)
                  report_mismatch("padding bit not zero");
               case (exp.status)
                  STATUS_FOUND:    found_count++;
                  STATUS_INSERTED: inserted_count++;
                  default:         dropped_count++;
               endcase
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            awaited_lookups.push_back(search_swap_insert(req_tdata));
            lookups_seen++;
         end
         pending = awaited_lookups.size();
      end
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the sorted key table: a directed opening on an
// empty table, then random keys that fill it and keep hitting it when full
// ----------------------------------------------------------------------------
module tb;
   import stsi_pkg::*;

   localparam int               RANDOM_KEYS  = 740;
   localparam int               CYCLE_LIMIT  = 400_000;
   localparam int               DRAIN_CYCLES = 200;
   localparam logic [KEY_W-1:0] KEY_MIN      = 32'h8000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX      = 32'h7FFF_FFFF;
   localparam logic [KEY_W-1:0] KEY_ZERO     = 32'h0000_0000;
   localparam logic [KEY_W-1:0] KEY_NEG_ONE  = 32'hFFFF_FFFF;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int mismatch_count;
   int pending;
   int found_count;
   int inserted_count;
   int dropped_count;
   int cycles = 0;
   bit calm   = 1'b0;

   logic [KEY_W-1:0] sent_keys [$];

   always #5 clock = ~clock;

   sorted_table_search_swap_insert_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   key_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending        (pending),
      .found_count    (found_count),
      .inserted_count (inserted_count),
      .dropped_count  (dropped_count)
   );

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 12);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // valid stays high between back-to-back transactions
   task automatic send_key(input logic [KEY_W-1:0] key);
      while (!calm && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sent_keys.push_back(key);
   endtask

   // repeats of earlier keys drive hits, the rest are fresh or extreme
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45 && sent_keys.size() > 0)
         return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      else if (roll < 70)
         return $urandom;
      else if (roll < 92)
         return 32'($urandom_range(0, 200)) - 32'd100;
      case ($urandom_range(0, 3))
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2:       return KEY_ZERO;
         default: return KEY_NEG_ONE;
      endcase
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_key(KEY_ZERO);        // insert into empty table
      send_key(KEY_ZERO);        // hit on the only entry, nothing moves
      send_key(KEY_MIN);         // insert at the bottom
      send_key(KEY_MAX);         // insert at the top
      send_key(KEY_NEG_ONE);     // insert mid-table
      send_key(32'd1);
      send_key(KEY_MIN);         // hit, swapped with its successor
      send_key(KEY_MIN);         // search over a table no longer in order
      send_key(32'd100);
      send_key(KEY_MAX);         // hit on the last entry
      send_key(32'hFFFF_FFFE);
      send_key(32'h5555_5555);
      send_key(32'hAAAA_AAAA);
      send_key(KEY_NEG_ONE);
      send_key(32'd100);

      for (int n = 0; n < RANDOM_KEYS; n++) begin
         calm = (n >= 300 && n < 420);
         send_key(pick_key());
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      // let the checker log the last accepted key before polling
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d keys looked up: %0d found, %0d inserted, %0d dropped on a full table",
               sent_keys.size(), found_count, inserted_count, dropped_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
